@@ sv/uta_pkg.sv @@
package uta_pkg;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] DEC_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;  // 'A'

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_FETCH,
    S_SHOW
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DEC_RADIX) begin
      r = CHAR_ZERO + {1'b0, d};
    end else begin
      r = CHAR_A + {1'b0, d - DEC_RADIX};
    end
    return r;
  endfunction

endpackage

@@ sv/uta_ram.sv @@
module uta_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/uta_div.sv @@
// Restoring divider, one quotient bit per cycle. Quotient and remainder
// hold after the last step until the next start.
module uta_div #(
  parameter int unsigned W = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [W-1:0]               dividend,
  input  logic [uta_pkg::BASE_W-1:0] divisor,
  output logic                       last_step,
  output logic [W-1:0]               quotient,
  output logic [uta_pkg::BASE_W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W);

  logic                       busy;
  logic [CW-1:0]              cnt;
  logic [uta_pkg::BASE_W:0]   trial;
  logic                       fits;
  logic [uta_pkg::BASE_W-1:0] rem_next;

  assign trial     = {remainder, quotient[W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign rem_next  = fits ? uta_pkg::BASE_W'(trial - {1'b0, divisor})
                          : trial[uta_pkg::BASE_W-1:0];
  assign last_step = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[W-2:0], fits};
      remainder <= rem_next;
    end
  end

endmodule

@@ sv/unsigned_to_radix_ascii.sv @@
// Each digit costs one pass of the bit-serial divider and is stored in the
// digit buffer; digits are then shown, each by a buffer read then an output,
// plus out_ready stalls.
// Digit count, set by value and base, drives the total time per item.
// Throughput: one item at a time; in_ready is high only while idle.
// Reset: synchronous, active high; returns to idle, no item in flight.
module unsigned_to_radix_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [5:0]  base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  digit_char,
  output logic [6:0]  digit_count,
  output logic        last_digit
);

  localparam int unsigned AW = $clog2(VALUE_WIDTH);

  uta_pkg::state_t state, state_next;

  logic [uta_pkg::BASE_W-1:0]  base_r, base_sat;
  logic [uta_pkg::COUNT_W-1:0] n, n_next;
  logic [AW-1:0]               idx, idx_next;

  logic                       div_start;
  logic [VALUE_WIDTH-1:0]     div_dividend;
  logic                       div_last;
  logic [VALUE_WIDTH-1:0]     div_quot;
  logic [uta_pkg::BASE_W-1:0] div_rem;

  logic                       ram_we;
  logic [uta_pkg::BASE_W-1:0] ram_rdata;

  always_comb begin
    if (base < uta_pkg::BASE_MIN) begin
      base_sat = uta_pkg::BASE_MIN;
    end else if (base > uta_pkg::BASE_MAX) begin
      base_sat = uta_pkg::BASE_MAX;
    end else begin
      base_sat = base;
    end
  end

  uta_div #(.W(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((state == uta_pkg::S_IDLE) ? base_sat : base_r),
    .last_step (div_last),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // remainders land least significant first, read back from the top down
  uta_ram #(.WIDTH(uta_pkg::BASE_W), .DEPTH(VALUE_WIDTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n[AW-1:0]),
    .wdata (div_rem),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uta_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == uta_pkg::S_IDLE) begin
      base_r <= base_sat;
    end
    n   <= n_next;
    idx <= idx_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    idx_next     = idx;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    ram_we       = 1'b0;
    unique case (state)
      uta_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        div_dividend = value[VALUE_WIDTH-1:0];
        if (in_valid) begin
          div_start  = 1'b1;
          n_next     = '0;
          state_next = uta_pkg::S_DIV;
        end
      end
      uta_pkg::S_DIV: begin
        if (div_last) begin
          state_next = uta_pkg::S_STORE;
        end
      end
      uta_pkg::S_STORE: begin
        ram_we = 1'b1;
        n_next = n + 1'b1;
        if (div_quot == '0) begin
          idx_next   = n[AW-1:0];
          state_next = uta_pkg::S_FETCH;
        end else begin
          div_start  = 1'b1;
          state_next = uta_pkg::S_DIV;
        end
      end
      uta_pkg::S_FETCH: begin
        state_next = uta_pkg::S_SHOW;
      end
      uta_pkg::S_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx == '0) begin
            state_next = uta_pkg::S_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = uta_pkg::S_FETCH;
          end
        end
      end
      default: begin
        state_next = uta_pkg::S_IDLE;
      end
    endcase
  end

  assign digit_char  = uta_pkg::digit_to_ascii(ram_rdata);
  assign digit_count = n;
  assign last_digit  = (idx == '0);

endmodule
